// ----- rtl/core/wmm_pkg.sv -----
// wmm_pkg: shared constants for the waveform min/max decimator
// register index codes of the configuration port and their width
// no dependencies
`timescale 1ns / 1ps

package wmm_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_TOTAL_SAMPLES = 2'd0;
    localparam cfg_index_t REG_BUCKET_COUNT  = 2'd1;
    localparam cfg_index_t REG_CHANNEL_COUNT = 2'd2;

endpackage

// ----- rtl/core/wmm_lane.sv -----
// wmm_lane: one channel lane, folds its sample into the running min and max
// depends on wmm_pkg; instantiated once per channel by the top level
`timescale 1ns / 1ps

module wmm_lane
    import wmm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24
)
(
    input  logic                          lane_enable,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] run_min,
    input  logic signed [SAMPLE_BITS-1:0] run_max,
    output logic signed [SAMPLE_BITS-1:0] lane_min,
    output logic signed [SAMPLE_BITS-1:0] lane_max
);

    // disabled lane passes the running values through untouched
    assign lane_min = (lane_enable && (sample < run_min)) ? sample : run_min;
    assign lane_max = (lane_enable && (sample > run_max)) ? sample : run_max;

endmodule

// ----- rtl/core/wmm_merge.sv -----
// wmm_merge: combines the per-lane min and max into one result per frame
// depends on wmm_pkg; fed by the wmm_lane instances
`timescale 1ns / 1ps

module wmm_merge
    import wmm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24
)
(
    input  logic signed [SAMPLE_BITS-1:0] left_min,
    input  logic signed [SAMPLE_BITS-1:0] left_max,
    input  logic signed [SAMPLE_BITS-1:0] right_min,
    input  logic signed [SAMPLE_BITS-1:0] right_max,
    output logic signed [SAMPLE_BITS-1:0] merged_min,
    output logic signed [SAMPLE_BITS-1:0] merged_max
);

    assign merged_min = (right_min < left_min) ? right_min : left_min;
    assign merged_max = (right_max > left_max) ? right_max : left_max;

endmodule

// ----- rtl/core/waveform_min_max_decimator_unit.sv -----
// a closing input transfer writes its result straight into the output register
// throughput: one sample frame per cycle; a frame is taken while a result waits
// as long as the output register is empty or being drained in the same cycle
// reset (rst_n low, asynchronous): registers go to 1 frame, 1 bucket, stereo;
// accumulation restarts at bucket 0 with min +1.0 and max -1.0, no result pending
`timescale 1ns / 1ps

module waveform_min_max_decimator_unit
    import wmm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned BUCKET_BITS = 16,
    parameter int unsigned COUNT_BITS  = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [((COUNT_BITS > BUCKET_BITS) ? COUNT_BITS : BUCKET_BITS)-1:0] cfg_data,
    // sample frame input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,
    // bucket result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [BUCKET_BITS-1:0]        bucket_index,
    output logic signed [SAMPLE_BITS-1:0] bucket_min,
    output logic signed [SAMPLE_BITS-1:0] bucket_max,
    output logic                          last_bucket
);

    // common width for length and bucket arithmetic
    localparam int unsigned CW = (COUNT_BITS > BUCKET_BITS) ? COUNT_BITS : BUCKET_BITS;
    // +1.0 in signed Q2.(SAMPLE_BITS-2)
    localparam logic signed [SAMPLE_BITS-1:0] Q_ONE =
        SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [SAMPLE_BITS-1:0] Q_MINUS_ONE = -Q_ONE;

    // configuration registers
    logic [COUNT_BITS-1:0]  total_reg;
    logic [BUCKET_BITS-1:0] bcount_reg;
    logic [1:0]             chan_reg;

    // accumulation state
    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic [CW-1:0]                 dist_reg, dist_next;
    logic [BUCKET_BITS-1:0]        bucket_reg, bucket_next;
    // set when the next frame starts a fresh recording, so the boundary
    // distance comes from the current settings rather than dist_reg
    logic                          fresh_reg, fresh_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [BUCKET_BITS-1:0]        out_index_reg;
    logic signed [SAMPLE_BITS-1:0] out_min_reg;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic                          out_last_reg;

    // effective length and bucket count
    logic [CW-1:0]          n_eff;
    logic [CW-1:0]          bc_one;
    logic [CW-1:0]          b_wide;
    logic [BUCKET_BITS-1:0] b_eff;
    logic [CW-1:0]          n_minus_b;
    logic [CW-1:0]          dist_cur;
    logic                   stereo;

    logic                   cfg_hit;
    logic                   in_xfer;
    logic                   close_bucket;
    logic                   is_last;

    logic signed [SAMPLE_BITS-1:0] left_min, left_max;
    logic signed [SAMPLE_BITS-1:0] right_min, right_max;
    logic signed [SAMPLE_BITS-1:0] merged_min, merged_max;

    // zero length and zero buckets count as one; buckets clamp to length
    assign n_eff     = (total_reg == '0) ? CW'(1) : CW'(total_reg);
    assign bc_one    = (bcount_reg == '0) ? CW'(1) : CW'(bcount_reg);
    assign b_wide    = (bc_one > n_eff) ? n_eff : bc_one;
    assign b_eff     = b_wide[BUCKET_BITS-1:0];
    assign n_minus_b = n_eff - b_wide;
    assign dist_cur  = fresh_reg ? n_minus_b : dist_reg;
    assign stereo    = chan_reg[1];

    // only a write to a known register drops the recording in progress
    assign cfg_hit = cfg_we && ((cfg_index == REG_TOTAL_SAMPLES) ||
                                (cfg_index == REG_BUCKET_COUNT)  ||
                                (cfg_index == REG_CHANNEL_COUNT));

    // the output register frees up when empty or drained this cycle
    assign in_ready     = !out_valid_reg || out_ready;
    assign in_xfer      = in_valid && in_ready;
    assign close_bucket = (dist_cur < b_wide);
    assign is_last      = ({1'b0, bucket_reg} + (BUCKET_BITS+1)'(1)) >= {1'b0, b_eff};

    // one lane per channel, right lane gated off in mono
    wmm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left
    (
        .lane_enable (1'b1),
        .sample      (sample_left),
        .run_min     (run_min_reg),
        .run_max     (run_max_reg),
        .lane_min    (left_min),
        .lane_max    (left_max)
    );

    wmm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right
    (
        .lane_enable (stereo),
        .sample      (sample_right),
        .run_min     (run_min_reg),
        .run_max     (run_max_reg),
        .lane_min    (right_min),
        .lane_max    (right_max)
    );

    wmm_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge
    (
        .left_min   (left_min),
        .left_max   (left_max),
        .right_min  (right_min),
        .right_max  (right_max),
        .merged_min (merged_min),
        .merged_max (merged_max)
    );

    // accumulation and boundary tracking
    always_comb
    begin
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        dist_next    = dist_reg;
        bucket_next  = bucket_reg;
        fresh_next   = fresh_reg;
        if (cfg_hit)
        begin
            // any write to a known register drops the recording in progress
            run_min_next = Q_ONE;
            run_max_next = Q_MINUS_ONE;
            bucket_next  = '0;
            fresh_next   = 1'b1;
        end
        else if (in_xfer)
        begin
            fresh_next = 1'b0;
            if (!close_bucket)
            begin
                run_min_next = merged_min;
                run_max_next = merged_max;
                dist_next    = dist_cur - b_wide;
            end
            else
            begin
                run_min_next = Q_ONE;
                run_max_next = Q_MINUS_ONE;
                if (is_last)
                begin
                    bucket_next = '0;
                    fresh_next  = 1'b1;
                end
                else
                begin
                    bucket_next = bucket_reg + BUCKET_BITS'(1);
                    dist_next   = dist_cur + n_minus_b;
                end
            end
        end
    end

    // output register valid: loads on a closing frame, clears on drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer && close_bucket)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= COUNT_BITS'(1);
            bcount_reg    <= BUCKET_BITS'(1);
            chan_reg      <= 2'd2;
            run_min_reg   <= Q_ONE;
            run_max_reg   <= Q_MINUS_ONE;
            dist_reg      <= '0;
            bucket_reg    <= '0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TOTAL_SAMPLES: total_reg  <= cfg_data[COUNT_BITS-1:0];
                    REG_BUCKET_COUNT:  bcount_reg <= cfg_data[BUCKET_BITS-1:0];
                    REG_CHANNEL_COUNT: chan_reg   <= cfg_data[1:0];
                    default:           ; // unknown index ignored
                endcase
            end
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            dist_reg      <= dist_next;
            bucket_reg    <= bucket_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, captured from the merged values of the closing frame
    always_ff @(posedge clk)
    begin
        if (in_xfer && close_bucket)
        begin
            out_index_reg <= bucket_reg;
            out_min_reg   <= merged_min;
            out_max_reg   <= merged_max;
            out_last_reg  <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bucket_index = out_index_reg;
    assign bucket_min   = out_min_reg;
    assign bucket_max   = out_max_reg;
    assign last_bucket  = out_last_reg;

`ifndef SYNTHESIS
    // a closing frame always lands in the output register
    a_close_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && close_bucket) |=> out_valid_reg)
        else $error("closing frame did not produce a result");

    // boundary distance stays below the recording length once a recording is under way
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        !fresh_reg |-> (dist_reg < n_eff))
        else $error("boundary distance out of range");

    // a delivered result never lies outside the initial bounds
    a_result_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_min_reg <= Q_ONE) && (out_max_reg >= Q_MINUS_ONE)))
        else $error("bucket min or max beyond the one bound");

    // the final bucket carries the last index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && close_bucket && is_last) |=>
            (({1'b0, out_index_reg} + (BUCKET_BITS+1)'(1)) >= {1'b0, b_eff}))
        else $error("last bucket flagged at wrong index");
`endif

endmodule
